// File: rtl/core/imadec_pkg.sv
// Shared types, constants and the nibble decode function for the IMA ADPCM clip decoder.
// Depends on nothing; every other file of the core imports it.
`default_nettype none

package imadec_pkg;

   localparam logic [3:0] HEADER_LEN = 4'd8;
   localparam logic [6:0] STEP_MAX   = 7'd88;

   typedef struct packed {
      logic [7:0] clip_byte;
      logic       clip_start;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pcm_sample;
      logic               last_of_byte;
      logic               clip_done;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_PRED_LO,
      CMD_PRED_HI,
      CMD_STEP,
      CMD_DECODE1,
      CMD_DECODE2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] data;
      logic       done;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] pred;
      logic [6:0]         idx;
   } decode_result_type;

   localparam logic [15:0] STEP_TABLE [0:88] = '{
      16'd7, 16'd8, 16'd9, 16'd10, 16'd11, 16'd12, 16'd13, 16'd14,
      16'd16, 16'd17, 16'd19, 16'd21, 16'd23, 16'd25, 16'd28, 16'd31,
      16'd34, 16'd37, 16'd41, 16'd45, 16'd50, 16'd55, 16'd60, 16'd66,
      16'd73, 16'd80, 16'd88, 16'd97, 16'd107, 16'd118, 16'd130, 16'd143,
      16'd157, 16'd173, 16'd190, 16'd209, 16'd230, 16'd253, 16'd279, 16'd307,
      16'd337, 16'd371, 16'd408, 16'd449, 16'd494, 16'd544, 16'd598, 16'd658,
      16'd724, 16'd796, 16'd876, 16'd963, 16'd1060, 16'd1166, 16'd1282, 16'd1411,
      16'd1552, 16'd1707, 16'd1878, 16'd2066, 16'd2272, 16'd2499, 16'd2749, 16'd3024,
      16'd3327, 16'd3660, 16'd4026, 16'd4428, 16'd4871, 16'd5358, 16'd5894, 16'd6484,
      16'd7132, 16'd7845, 16'd8630, 16'd9493, 16'd10442, 16'd11487, 16'd12635, 16'd13899,
      16'd15289, 16'd16818, 16'd18500, 16'd20350, 16'd22385, 16'd24623, 16'd27086, 16'd29794,
      16'd32767
   };

   // One IMA ADPCM code applied to a predictor and step index.
   function automatic decode_result_type decode_nibble(input logic signed [15:0] pred,
                                                       input logic [6:0] idx,
                                                       input logic [3:0] code);
      logic [6:0]         sp;
      logic [15:0]        step;
      logic [16:0]        delta;
      logic signed [17:0] value;
      logic signed [7:0]  adj;
      logic signed [7:0]  nidx;
      decode_result_type  res;
      sp    = (idx > STEP_MAX) ? STEP_MAX : idx;
      step  = STEP_TABLE[sp];
      delta = {4'b0000, step[15:3]};
      if (code[2]) delta = delta + {1'b0, step};
      if (code[1]) delta = delta + {2'b00, step[15:1]};
      if (code[0]) delta = delta + {3'b000, step[15:2]};
      if (code[3]) begin
         value = $signed({{2{pred[15]}}, pred}) - $signed({1'b0, delta});
      end else begin
         value = $signed({{2{pred[15]}}, pred}) + $signed({1'b0, delta});
      end
      if (value > 18'sd32767) begin
         res.pred = 16'sh7FFF;
      end else if (value < -18'sd32768) begin
         res.pred = 16'sh8000;
      end else begin
         res.pred = value[15:0];
      end
      adj  = code[2] ? ($signed({5'b00000, code[1:0], 1'b0}) + 8'sd2) : -8'sd1;
      nidx = $signed({1'b0, sp}) + adj;
      if (nidx < 8'sd0) begin
         res.idx = 7'd0;
      end else if (nidx > $signed({1'b0, STEP_MAX})) begin
         res.idx = STEP_MAX;
      end else begin
         res.idx = nidx[6:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/imadec_front.sv
// Front end: parses clip headers, tracks the remaining sample count and
// turns the predictor, step and data bytes it accepts into commands for the decode back end. Uses imadec_pkg.
`default_nettype none

module imadec_front import imadec_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         cmd_push,
   output cmd_type      cmd_data,
   input  wire logic    cmd_full
);

   logic [3:0]  header_pos_ff, header_pos_in;
   logic [31:0] samples_left_ff, samples_left_in;
   logic [3:0]  pos;
   logic        accept;

   assign full   = cmd_full;
   assign accept = push && !cmd_full;
   assign pos    = req_data.clip_start ? 4'd0 : header_pos_ff;

   always_comb begin
      header_pos_in   = header_pos_ff;
      samples_left_in = samples_left_ff;
      cmd_push        = 1'b0;
      cmd_data.op     = CMD_DECODE2;
      cmd_data.data   = req_data.clip_byte;
      cmd_data.done   = 1'b0;
      if (accept) begin
         if (pos < HEADER_LEN) begin
            header_pos_in = pos + 4'd1;
            case (pos)
               4'd0: samples_left_in = {24'h000000, req_data.clip_byte};
               4'd1: samples_left_in[15:8]  = req_data.clip_byte;
               4'd2: samples_left_in[23:16] = req_data.clip_byte;
               4'd3: samples_left_in[31:24] = req_data.clip_byte;
               4'd4: begin
                  cmd_push    = 1'b1;
                  cmd_data.op = CMD_PRED_LO;
               end
               4'd5: begin
                  cmd_push    = 1'b1;
                  cmd_data.op = CMD_PRED_HI;
               end
               4'd6: begin
                  cmd_push    = 1'b1;
                  cmd_data.op = CMD_STEP;
                  if (req_data.clip_byte > {1'b0, STEP_MAX}) begin
                     cmd_data.data = {1'b0, STEP_MAX};
                  end
               end
               default: ;
            endcase
         end else if (samples_left_ff != 32'd0) begin
            cmd_push = 1'b1;
            if (samples_left_ff == 32'd1) begin
               // A lone remaining sample uses the high nibble only.
               cmd_data.op     = CMD_DECODE1;
               cmd_data.done   = 1'b1;
               samples_left_in = 32'd0;
            end else begin
               cmd_data.op     = CMD_DECODE2;
               cmd_data.done   = (samples_left_ff == 32'd2);
               samples_left_in = samples_left_ff - 32'd2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pos_ff   <= HEADER_LEN;
         samples_left_ff <= 32'd0;
      end else begin
         header_pos_ff   <= header_pos_in;
         samples_left_ff <= samples_left_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/imadec_cmd_queue.sv
// Two-entry command queue between the front end and the decode back end.
// Uses cmd_type from imadec_pkg.
`default_nettype none

module imadec_cmd_queue import imadec_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_push,
   input  wire cmd_type wr_data,
   output logic         wr_full,
   input  wire logic    rd_pop,
   output cmd_type      rd_data,
   output logic         rd_empty
);

   cmd_type    entry_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign wr_full  = (count_ff == 2'd2);
   assign rd_empty = (count_ff == 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_push  = wr_push && !wr_full;
   assign do_pop   = rd_pop && !rd_empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/imadec_back.sv
// Decode back end: executes queued commands, keeps predictor and step index,
// decodes one nibble per cycle, while the result queue has room, into a two-entry result queue. Uses imadec_pkg.
`default_nettype none

module imadec_back import imadec_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd_data,
   input  wire logic    cmd_empty,
   output logic         cmd_pop,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic signed [15:0] pred_ff, pred_in;
   logic [6:0]         step_ff, step_in;
   logic               phase_ff, phase_in;
   rsp_type            out_q_ff [0:1];
   logic               out_wr_ff, out_wr_in;
   logic               out_rd_ff, out_rd_in;
   logic [1:0]         out_count_ff, out_count_in;
   logic               out_full, out_push, out_pop;
   rsp_type            out_entry;
   logic [3:0]         code;
   decode_result_type  dec;

   assign out_full = (out_count_ff == 2'd2);
   assign out_pop  = pop && !empty;
   assign empty    = (out_count_ff == 2'd0);
   assign rsp_data = out_q_ff[out_rd_ff];
   assign code     = phase_ff ? cmd_data.data[3:0] : cmd_data.data[7:4];
   assign dec      = decode_nibble(pred_ff, step_ff, code);

   always_comb begin
      pred_in                = pred_ff;
      step_in                = step_ff;
      phase_in               = phase_ff;
      cmd_pop                = 1'b0;
      out_push               = 1'b0;
      out_entry.pcm_sample   = dec.pred;
      out_entry.last_of_byte = 1'b0;
      out_entry.clip_done    = 1'b0;
      if (!cmd_empty) begin
         case (cmd_data.op)
            CMD_PRED_LO: begin
               pred_in = $signed({8'h00, cmd_data.data});
               cmd_pop = 1'b1;
            end
            CMD_PRED_HI: begin
               pred_in = $signed({cmd_data.data, pred_ff[7:0]});
               cmd_pop = 1'b1;
            end
            CMD_STEP: begin
               step_in = cmd_data.data[6:0];
               cmd_pop = 1'b1;
            end
            CMD_DECODE1: begin
               if (!out_full) begin
                  out_push               = 1'b1;
                  out_entry.last_of_byte = 1'b1;
                  out_entry.clip_done    = 1'b1;
                  pred_in                = dec.pred;
                  step_in                = dec.idx;
                  cmd_pop                = 1'b1;
               end
            end
            CMD_DECODE2: begin
               if (!out_full) begin
                  out_push = 1'b1;
                  pred_in  = dec.pred;
                  step_in  = dec.idx;
                  if (phase_ff) begin
                     out_entry.last_of_byte = 1'b1;
                     out_entry.clip_done    = cmd_data.done;
                     cmd_pop                = 1'b1;
                     phase_in               = 1'b0;
                  end else begin
                     phase_in = 1'b1;
                  end
               end
            end
            default: cmd_pop = 1'b1;
         endcase
      end
   end

   always_comb begin
      out_wr_in    = out_push ? !out_wr_ff : out_wr_ff;
      out_rd_in    = out_pop ? !out_rd_ff : out_rd_ff;
      out_count_in = out_count_ff + {1'b0, out_push} - {1'b0, out_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff      <= 16'sd0;
         step_ff      <= 7'd0;
         phase_ff     <= 1'b0;
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         pred_ff      <= pred_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_q_ff[out_wr_ff] <= out_entry;
      end
   end

   // The step index must stay inside the step table.
   assert property (@(posedge clock) disable iff (reset) step_ff <= STEP_MAX)
      else $error("step index beyond table");

   // The result queue never holds more than two entries.
   assert property (@(posedge clock) disable iff (reset) out_count_ff <= 2'd2)
      else $error("result queue overflow");

   // The second nibble phase only exists while its two-sample command is at the head.
   assert property (@(posedge clock) disable iff (reset)
                    phase_ff |-> (!cmd_empty && cmd_data.op == CMD_DECODE2))
      else $error("second nibble phase without a two-sample command");

   // Finishing a two-sample command always emits the last sample of its byte.
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff && cmd_pop) |-> (out_push && out_entry.last_of_byte))
      else $error("two-sample command retired without its final sample");

endmodule

`default_nettype wire

// File: rtl/core/ima_adpcm_clip_decoder_core.sv
// Path: a data byte accepted by the front end is written into the command queue; the back end
// decodes its first sample into the result queue, where it can be popped; the second follows.
// Throughput: one byte per cycle on the request side while the command queue has room;
// data bytes go slower, set by the back end's one-nibble-per-cycle decoder.
// Reset (synchronous, active high) empties both queues, marks the header complete and
// clears count, predictor and step index, so bytes before the first clip_start give nothing.
`default_nettype none

module ima_adpcm_clip_decoder_core import imadec_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_wr_data, cmd_rd_data;

   imadec_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wr_data),
      .cmd_full (cmd_full)
   );

   imadec_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (cmd_push),
      .wr_data  (cmd_wr_data),
      .wr_full  (cmd_full),
      .rd_pop   (cmd_pop),
      .rd_data  (cmd_rd_data),
      .rd_empty (cmd_empty)
   );

   imadec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_rd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
